[sv/drl_pkg.sv]
// Shared constants and control/status types for the DDA line rasterizer.
`default_nettype none

package drl_pkg;

    // Width of every coordinate port.
    localparam int FIELD_W = 6;

    // Default coordinate width and slope fraction width.
    localparam int COORD_BITS_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // Capture and order a new segment.
        logic div_start;    // Start the slope division.
        logic latch_slope;  // Capture the signed slope from the divider.
        logic emit;         // Load the current pixel into the output word and advance.
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;     // The segment is a single point.
        logic div_done;     // The slope quotient is ready.
        logic out_free;     // The output register can take a word this cycle.
        logic at_last;      // The current pixel is the last one of the segment.
    } stat_t;

endpackage

`default_nettype wire

[sv/drl_div.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module drl_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo,
    output logic                  done
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // The dividend shifts out of the top of the quotient register while
    // quotient bits shift in at the bottom.
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(NUM_W);
            rem_next = '0;
            quo_next = num;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[sv/drl_datapath.sv]
// Datapath: endpoint ordering, slope division, accumulator and output word register.
`default_nettype none

module drl_datapath #(
    parameter int COORD_BITS = drl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = drl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire drl_pkg::cmd_t                 cmd,
    output drl_pkg::stat_t                     stat,
    input  wire logic [drl_pkg::FIELD_W-1:0]   start_x,
    input  wire logic [drl_pkg::FIELD_W-1:0]   start_y,
    input  wire logic [drl_pkg::FIELD_W-1:0]   end_x,
    input  wire logic [drl_pkg::FIELD_W-1:0]   end_y,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [drl_pkg::FIELD_W-1:0]        pixel_x,
    output logic [drl_pkg::FIELD_W-1:0]        pixel_y,
    output logic                               last_pixel
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NW = C + F;
    localparam int AW = C + F + 2;
    localparam int FW = drl_pkg::FIELD_W;

    // Endpoint decode and ordering.
    logic signed [C-1:0] x0, y0, x1, y1;
    logic signed [C:0]   dx, dy, dmin;
    logic signed [C:0]   adx_s, ady_s, amin_s;
    logic [C-1:0]        adx, ady;
    logic                xmajor, swap;
    logic signed [C-1:0] a0, b0, b1;

    always_comb
    begin
        x0     = start_x[C-1:0];
        y0     = start_y[C-1:0];
        x1     = end_x[C-1:0];
        y1     = end_y[C-1:0];
        dx     = (C+1)'(x1) - (C+1)'(x0);
        dy     = (C+1)'(y1) - (C+1)'(y0);
        adx_s  = dx[C] ? -dx : dx;
        ady_s  = dy[C] ? -dy : dy;
        adx    = adx_s[C-1:0];
        ady    = ady_s[C-1:0];
        xmajor = (ady <= adx);
        swap   = xmajor ? (x0 > x1) : (y0 > y1);
        if (xmajor)
        begin
            a0 = swap ? x1 : x0;
            b0 = swap ? y1 : y0;
            b1 = swap ? y0 : y1;
        end
        else
        begin
            a0 = swap ? y1 : y0;
            b0 = swap ? x1 : x0;
            b1 = swap ? x0 : x1;
        end
        dmin   = (C+1)'(b1) - (C+1)'(b0);
        amin_s = dmin[C] ? -dmin : dmin;
    end

    logic                 xmajor_reg;
    logic [C-1:0]         major_reg, major_next;
    logic [C-1:0]         len_reg;
    logic [C-1:0]         cnt_reg, cnt_next;
    logic [C-1:0]         amin_reg;
    logic                 neg_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] slope_reg, slope_next;

    // Slope division: (amin * 2^F + len / 2) / len.
    logic [NW-1:0] div_num;
    logic [NW-1:0] div_quo;
    logic          div_done;
    logic [AW-1:0] smag;

    assign div_num = {amin_reg, {(F - C + 1){1'b0}}, len_reg[C-1:1]};

    drl_div #(
        .NUM_W (NW),
        .DEN_W (C)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (len_reg),
        .quo   (div_quo),
        .done  (div_done)
    );

    assign smag       = AW'(div_quo[F:0]);
    assign slope_next = neg_reg ? -$signed(smag) : $signed(smag);

    // Round the accumulator half away from zero: a negative value takes
    // one less than a half before the floor shift.
    localparam logic [AW-1:0] HALF = AW'(1) << (F - 1);

    logic [AW-1:0]       round_sum;
    logic signed [C-1:0] minor;
    logic signed [C-1:0] major;
    logic [FW-1:0]       px, py;

    always_comb
    begin
        round_sum = acc_reg + (acc_reg[AW-1] ? (HALF - AW'(1)) : HALF);
        minor     = round_sum[F+C-1:F];
        major     = major_reg;
        px        = xmajor_reg ? FW'(major) : FW'(minor);
        py        = xmajor_reg ? FW'(minor) : FW'(major);
    end

    always_comb
    begin
        major_next = major_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        if (cmd.load)
        begin
            major_next = a0;
            cnt_next   = '0;
            acc_next   = {{2{b0[C-1]}}, b0, {F{1'b0}}};
        end
        else if (cmd.emit)
        begin
            major_next = major_reg + C'(1);
            cnt_next   = cnt_reg + C'(1);
            acc_next   = acc_reg + slope_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg <= major_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        if (cmd.load)
        begin
            xmajor_reg <= xmajor;
            len_reg    <= xmajor ? adx : ady;
            amin_reg   <= amin_s[C-1:0];
            neg_reg    <= dmin[C];
        end
        if (cmd.latch_slope)
        begin
            slope_reg <= slope_next;
        end
    end

    // Output word register.
    logic          out_valid_reg, out_valid_next;
    logic [FW-1:0] pixel_x_reg, pixel_y_reg;
    logic          last_reg;

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_x_reg <= px;
            pixel_y_reg <= py;
            last_reg    <= (cnt_reg == len_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_reg;

    always_comb
    begin
        stat.len_zero = (len_reg == '0);
        stat.div_done = div_done;
        stat.out_free = !out_valid_reg || out_ready;
        stat.at_last  = (cnt_reg == len_reg);
    end

endmodule

`default_nettype wire

[sv/drl_ctrl.sv]
// Controller state machine that sequences segment load, slope division and pixel output.
`default_nettype none

module drl_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire drl_pkg::stat_t stat,
    output drl_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.len_zero)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.latch_slope = 1'b1;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[sv/dda_line_rasterizer_core.sv]
// Top level of the DDA line rasterizer: controller and datapath.
//
// The block takes one line segment per input word, given as two signed
// endpoints, and returns one output word per plotted pixel, with last_pixel
// set on the final one. The pixels run along the major axis (x when
// |dy| <= |dx|, otherwise y) from the smaller to the larger major coordinate,
// whichever endpoint comes first, and the minor coordinate follows a signed
// fixed-point slope with FRAC_BITS fraction bits, rounded half away from zero.
// A segment whose endpoints coincide yields a single pixel. Only the low
// COORD_BITS bits of each input coordinate are used, and output coordinates
// are sign-extended to the port width. One segment is worked on at a time:
// a segment is loaded, set up, run through the bit-serial slope divider
// (skipped for a single point) and then output, one pixel per cycle while
// out_ready stays high. The input is ready again as soon as the last pixel
// has entered the output register, so the next segment loads while that
// word still waits to be taken.
`default_nettype none

module dda_line_rasterizer_core #(
    parameter int COORD_BITS = drl_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = drl_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [drl_pkg::FIELD_W-1:0] start_x,
    input  wire logic [drl_pkg::FIELD_W-1:0] start_y,
    input  wire logic [drl_pkg::FIELD_W-1:0] end_x,
    input  wire logic [drl_pkg::FIELD_W-1:0] end_y,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [drl_pkg::FIELD_W-1:0]      pixel_x,
    output logic [drl_pkg::FIELD_W-1:0]      pixel_y,
    output logic                             last_pixel
);

    // Command and status groups between the controller and the datapath.
    drl_pkg::cmd_t  cmd;
    drl_pkg::stat_t stat;

    // The controller owns the input handshake and steps the datapath.
    drl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath orders the endpoints, divides out the slope, runs the
    // accumulator and holds the output word.
    drl_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the DDA line rasterizer core.
`default_nettype none

module tb;

    localparam int W          = drl_pkg::FIELD_W;
    localparam int COORD_BITS = drl_pkg::COORD_BITS_DEF;
    localparam int FRAC_BITS  = drl_pkg::FRAC_BITS_DEF;

    // A whole run of accept-free cycles this long means the block is stuck.
    localparam int STALL_LIMIT = 3000;
    // Idle time after the final drain, set past the longest segment.
    localparam int SETTLE_CYCLES = 120;

    // One pixel as the output channel presents it.
    typedef struct packed {
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic         last;
    } pixel_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_ready;
    logic [W-1:0] start_x = '0;
    logic [W-1:0] start_y = '0;
    logic [W-1:0] end_x = '0;
    logic [W-1:0] end_y = '0;
    logic         out_valid;
    logic         out_ready = 1'b0;
    logic [W-1:0] pixel_x;
    logic [W-1:0] pixel_y;
    logic         last_pixel;

    // Pixels predicted for accepted segments, oldest first.
    pixel_t pending_pixels[$];

    int sender_idle_pct = 34;
    int recv_idle_pct   = 72;
    int error_count     = 0;
    int segments_sent   = 0;
    int pixels_checked  = 0;
    int quiet_cycles    = 0;

    dda_line_rasterizer_core #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last_pixel(last_pixel)
    );

    always #5 clk = ~clk;

    // Sign-extend the low COORD_BITS bits of a coordinate port value.
    function automatic longint coord_value(logic [W-1:0] raw);
        longint m;
        m = longint'(raw) & ((longint'(1) << COORD_BITS) - 1);
        if (m[COORD_BITS-1])
        begin
            m = m - (longint'(1) << COORD_BITS);
        end
        return m;
    endfunction

    // Work out every pixel of one segment and queue them in plotting order.
    // The major axis is x unless |dy| > |dx|; the run goes from the smaller
    // major coordinate upward, and the minor coordinate follows a fixed-point
    // slope that is rounded half away from zero at each step.
    function automatic void plot_segment(logic [W-1:0] sx, logic [W-1:0] sy,
                                         logic [W-1:0] ex, logic [W-1:0] ey);
        longint x0, y0, x1, y1, adx, ady;
        longint a0, len, b0, dmin, amin, smag, slope, acc, mag, minor, major;
        bit     xmajor;
        pixel_t p;
        x0 = coord_value(sx);
        y0 = coord_value(sy);
        x1 = coord_value(ex);
        y1 = coord_value(ey);
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (adx == 0 && ady == 0)
        begin
            p.x = W'(x0);
            p.y = W'(y0);
            p.last = 1'b1;
            pending_pixels.push_back(p);
            return;
        end
        xmajor = (ady <= adx);
        if (xmajor)
        begin
            if (x0 > x1)
            begin
                a0 = x1; len = x0 - x1; b0 = y1; dmin = y0 - y1;
            end
            else
            begin
                a0 = x0; len = x1 - x0; b0 = y0; dmin = y1 - y0;
            end
        end
        else
        begin
            if (y0 > y1)
            begin
                a0 = y1; len = y0 - y1; b0 = x1; dmin = x0 - x1;
            end
            else
            begin
                a0 = y0; len = y1 - y0; b0 = x0; dmin = x1 - x0;
            end
        end
        amin  = (dmin < 0) ? -dmin : dmin;
        smag  = ((amin << FRAC_BITS) + len / 2) / len;
        slope = (dmin < 0) ? -smag : smag;
        for (longint k = 0; k <= len; k++)
        begin
            major = a0 + k;
            acc   = (b0 << FRAC_BITS) + k * slope;
            mag   = (acc < 0) ? -acc : acc;
            minor = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (acc < 0)
            begin
                minor = -minor;
            end
            p.x    = xmajor ? W'(major) : W'(minor);
            p.y    = xmajor ? W'(minor) : W'(major);
            p.last = (k == len);
            pending_pixels.push_back(p);
        end
    endfunction

    // Offer one segment word, optionally after a random gap, and hold it
    // until the block takes it. Valid stays high afterwards so that
    // back-to-back words need no second assignment in the same step.
    task automatic send_segment(logic [W-1:0] sx, logic [W-1:0] sy,
                                logic [W-1:0] ex, logic [W-1:0] ey);
        int gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        plot_segment(sx, sy, ex, ey);
        segments_sent++;
    endtask

    // Drop valid and hold off until every predicted pixel has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_pixels.size() != 0);
    endtask

    task automatic test_single_points();
        send_segment(6'sd0, 6'sd0, 6'sd0, 6'sd0);
        send_segment(-6'sd32, -6'sd32, -6'sd32, -6'sd32);
        send_segment(6'sd31, 6'sd31, 6'sd31, 6'sd31);
        send_segment(-6'sd32, 6'sd31, -6'sd32, 6'sd31);
    endtask

    // Full-width horizontal and vertical runs of 64 pixels, both directions.
    task automatic test_full_spans();
        send_segment(-6'sd32, 6'sd0, 6'sd31, 6'sd0);
        send_segment(6'sd31, 6'sd5, -6'sd32, 6'sd5);
        send_segment(6'sd3, -6'sd32, 6'sd3, 6'sd31);
        send_segment(-6'sd7, 6'sd31, -6'sd7, -6'sd32);
    endtask

    // Equal |dx| and |dy| keeps x as the major axis.
    task automatic test_diagonals();
        send_segment(-6'sd32, -6'sd32, 6'sd31, 6'sd31);
        send_segment(6'sd31, -6'sd32, -6'sd32, 6'sd31);
    endtask

    // Slopes of exactly one half land on .5 and must round away from zero.
    task automatic test_rounding_halves();
        send_segment(6'sd0, 6'sd0, 6'sd2, 6'sd1);
        send_segment(6'sd0, 6'sd0, 6'sd2, -6'sd1);
        send_segment(6'sd0, 6'sd0, 6'sd1, 6'sd2);
        send_segment(6'sd0, 6'sd0, -6'sd1, 6'sd2);
        send_segment(-6'sd5, 6'sd3, 6'sd1, 6'sd0);
    endtask

    // The same segment given in either order must plot the same run.
    task automatic test_endpoint_order();
        send_segment(-6'sd10, 6'sd4, 6'sd20, -6'sd9);
        send_segment(6'sd20, -6'sd9, -6'sd10, 6'sd4);
        send_segment(6'sd2, -6'sd20, -6'sd3, 6'sd25);
        send_segment(-6'sd3, 6'sd25, 6'sd2, -6'sd20);
    endtask

    // Random segments: a mix of arbitrary, short, axis-aligned, diagonal
    // and single-point segments, with a full drain halfway through.
    task automatic test_random_segments(int count, int snd_pct, int rcv_pct);
        logic [W-1:0] sx, sy, ex, ey, d;
        int           mode;
        sender_idle_pct = snd_pct;
        recv_idle_pct   = rcv_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                wait_for_drain();
            end
            mode = $urandom_range(99);
            sx = W'($urandom);
            sy = W'($urandom);
            ex = W'($urandom);
            ey = W'($urandom);
            d  = W'($urandom);
            if (mode >= 45 && mode < 80)
            begin
                ex = W'(sx + $urandom_range(0, 8) - 4);
                ey = W'(sy + $urandom_range(0, 8) - 4);
            end
            else if (mode >= 80 && mode < 88)
            begin
                if (mode[0])
                    ey = sy;
                else
                    ex = sx;
            end
            else if (mode >= 88 && mode < 96)
            begin
                ex = W'(sx + d);
                ey = mode[0] ? W'(sy + d) : W'(sy - d);
            end
            else if (mode >= 96)
            begin
                ex = sx;
                ey = sy;
            end
            send_segment(sx, sy, ex, ey);
        end
    endtask

    // Output side: compare every accepted pixel word with the oldest
    // prediction, then choose whether to stall the next cycle.
    always @(posedge clk)
    begin : pixel_checker
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t unexpected pixel word x=%0d y=%0d last=%0b", $time,
                         $signed(pixel_x), $signed(pixel_y), last_pixel);
                error_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (pixel_x !== want.x)
                begin
                    $display("%0t pixel_x mismatch: expected %0d actual %0d", $time,
                             $signed(want.x), $signed(pixel_x));
                    error_count++;
                end
                if (pixel_y !== want.y)
                begin
                    $display("%0t pixel_y mismatch: expected %0d actual %0d", $time,
                             $signed(want.y), $signed(pixel_y));
                    error_count++;
                end
                if (last_pixel !== want.last)
                begin
                    $display("%0t last_pixel mismatch: expected %0b actual %0b", $time,
                             want.last, last_pixel);
                    error_count++;
                end
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Count cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("dda_line_rasterizer_core test failed");
        $finish;
    end

    initial
    begin : run
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_points();
        test_full_spans();
        test_diagonals();
        test_rounding_halves();
        test_endpoint_order();

        test_random_segments(160, 34, 72);
        test_random_segments(160, 72, 34);
        test_random_segments(160, 0, 0);

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d segments and checked %0d pixels.", segments_sent,
                 pixels_checked);
        $display("Covered single points, full spans, diagonals, half-step rounding,");
        $display("both endpoint orders and random segments under three stall mixes.");
        if (error_count == 0 && pending_pixels.size() == 0)
        begin
            $display("dda_line_rasterizer_core test passed");
        end
        else
        begin
            if (pending_pixels.size() != 0)
                $display("%0t %0d predicted pixels never came out", $time,
                         pending_pixels.size());
            $display("dda_line_rasterizer_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
